// File: rtl/lsu_pkg.sv
// Package for the level set upwind update core: widths, register codes,
// reset values and the shared sideband and configuration types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lsu_pkg;

    localparam int DATA_W  = 32;   // Q16.16 values
    localparam int FAC_W   = 17;   // image factor, Q1.16
    localparam int STEP_W  = 20;   // step ratio, Q4.16
    localparam int PART_W  = 32;   // one-sided difference magnitude
    localparam int SQ_W    = 2 * PART_W;
    localparam int RAD_W   = SQ_W + 2;     // sum of up to four squares
    localparam int ROOT_W  = RAD_W / 2;
    localparam int PROD_W  = FAC_W + DATA_W;
    localparam int MAG_W   = PROD_W - 16;  // rounded speed magnitude
    localparam int TERM_W  = MAG_W + ROOT_W;
    localparam int TPART_W = TERM_W - 16;  // rounded term magnitude
    localparam int TOT_W   = TPART_W + 2;
    localparam int TMAG_W  = TOT_W - 1;
    localparam int TLO_W   = 26;
    localparam int THI_W   = TMAG_W - TLO_W;
    localparam int DPROD_W = STEP_W + TMAG_W;
    localparam int DMAG_W  = DPROD_W - 16;
    localparam int RES_W   = DMAG_W + 2;
    localparam int SQRT_LAT = ROOT_W;      // one root bit per stage

    localparam logic [15:0] ROUND_HALF = 16'h8000;

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_BASE_SPEED = 1'b0;
    localparam logic REG_STEP_RATIO = 1'b1;
    localparam logic signed [DATA_W-1:0] BASE_SPEED_RST = 32'sd65536;
    localparam logic [STEP_W-1:0]        STEP_RATIO_RST = 20'd6554;

    typedef struct packed {
        logic signed [DATA_W-1:0] base_speed;
        logic [STEP_W-1:0]        step_ratio;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] centre;
        logic [MAG_W-1:0]         cs_mag;
        logic [MAG_W-1:0]         ds_mag;
        logic                     cs_pos;
        logic                     curv_pos;
    } t_side;

endpackage
`default_nettype wire

// File: rtl/lsu_in_if.sv
// Pixel request channel: valid/ready handshake with the pixel fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface lsu_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] centre_value;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;
    logic signed [31:0] upper_value;
    logic signed [31:0] lower_value;
    logic [16:0]        image_factor;
    logic signed [31:0] curvature_speed;

    modport source (output valid, centre_value, left_value, right_value, upper_value,
                    lower_value, image_factor, curvature_speed, input ready);
    modport sink   (input valid, centre_value, left_value, right_value, upper_value,
                    lower_value, image_factor, curvature_speed, output ready);
endinterface
`default_nettype wire

// File: rtl/lsu_out_if.sv
// Result request channel: valid/ready handshake with the updated value.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface lsu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_value;
    logic               saturated;

    modport source (output valid, new_value, saturated, input ready);
    modport sink   (input valid, new_value, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/level_set_upwind_update_core.sv
// Top level of the level set upwind update core: registers, front stages,
// two root pipelines, back stages and the output skid. Depends on lsu_pkg,
// lsu_in_if, lsu_out_if, lsu_cfg, lsu_front, lsu_sqrt and lsu_back.
//
// Usage:
//   i_pix carries one pixel request (centre, four neighbours, image factor,
//   curvature speed); o_upd returns the updated value and a clip flag, one
//   result per request, in order. Both use valid/ready.
//   The APB port holds base_speed (0x0) and step_ratio (0x4); write them
//   only while no request is in flight.
//   Throughput: one request per cycle while the receiver keeps up. A request
//   passes 3 front stages, 33 root stages, 6 back stages and the output
//   register; the root pipeline, one result bit per stage, sets the depth.
//   When the receiver stalls, the pipeline keeps moving until one more result
//   sits in the skid register; then i_pix.ready drops and every stage holds.
//   Reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module level_set_upwind_update_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lsu_in_if.sink                              i_pix,
    lsu_out_if.source                           o_upd,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lsu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    localparam int LAT = lsu_pkg::SQRT_LAT;

    lsu_pkg::t_cfg  cfg;
    logic           en;
    logic           f_valid;
    lsu_pkg::t_side f_side;
    logic [lsu_pkg::RAD_W-1:0]  rad_up, rad_c;
    logic [lsu_pkg::ROOT_W-1:0] root_up, root_c;
    logic           b_valid;
    logic signed [31:0] b_nv;
    logic           b_sat;

    // advance the whole pipeline unless the skid register holds a result
    logic r_skid_v;
    assign en          = !r_skid_v;
    assign i_pix.ready = en;

    lsu_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready), .o_cfg(cfg)
    );

    lsu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_pix.valid),
        .i_centre_value(i_pix.centre_value), .i_left_value(i_pix.left_value),
        .i_right_value(i_pix.right_value), .i_upper_value(i_pix.upper_value),
        .i_lower_value(i_pix.lower_value), .i_image_factor(i_pix.image_factor),
        .i_curvature_speed(i_pix.curvature_speed), .i_cfg(cfg),
        .o_valid(f_valid), .o_side(f_side), .o_rad_up(rad_up), .o_rad_c(rad_c)
    );

    // upwind gradient root and central gradient root run side by side
    lsu_sqrt #(.RAD_W(lsu_pkg::RAD_W)) u_sqrt_up (
        .i_clk(i_clk), .i_en(en), .i_rad(rad_up), .o_root(root_up)
    );

    lsu_sqrt #(.RAD_W(lsu_pkg::RAD_W)) u_sqrt_c (
        .i_clk(i_clk), .i_en(en), .i_rad(rad_c), .o_root(root_c)
    );

    // carry valid bits and sideband alongside the root stages
    logic           r_dly_v    [LAT];
    lsu_pkg::t_side r_dly_side [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_dly_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_dly_v[0] <= f_valid;
            for (int k = 1; k < LAT; k++) begin
                r_dly_v[k] <= r_dly_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_side[0] <= f_side;
            for (int k = 1; k < LAT; k++) begin
                r_dly_side[k] <= r_dly_side[k-1];
            end
        end
    end

    lsu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_dly_v[LAT-1]),
        .i_side(r_dly_side[LAT-1]), .i_root_up(root_up), .i_root_c(root_c),
        .i_step_ratio(cfg.step_ratio),
        .o_valid(b_valid), .o_new_value(b_nv), .o_saturated(b_sat)
    );

    // output register plus one skid entry
    logic               r_out_v, r_out_sat, r_skid_sat;
    logic signed [31:0] r_out_nv, r_skid_nv;
    logic               take;

    assign take = !r_out_v || o_upd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            // drain the skid first; otherwise move the pipeline result up
            r_out_v  <= r_skid_v || b_valid;
            r_skid_v <= 1'b0;
        end else if (b_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_nv  <= r_skid_v ? r_skid_nv : b_nv;
            r_out_sat <= r_skid_v ? r_skid_sat : b_sat;
        end else if (en && b_valid) begin
            r_skid_nv  <= b_nv;
            r_skid_sat <= b_sat;
        end
    end

    assign o_upd.valid     = r_out_v;
    assign o_upd.new_value = r_out_nv;
    assign o_upd.saturated = r_out_sat;
endmodule
`default_nettype wire

// File: rtl/lsu_cfg.sv
// APB register file: base speed and step ratio.
// Depends on lsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsu_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lsu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output lsu_pkg::t_cfg                      o_cfg
);
    lsu_pkg::t_cfg r_cfg;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed <= lsu_pkg::BASE_SPEED_RST;
            r_cfg.step_ratio <= lsu_pkg::STEP_RATIO_RST;
        end else if (wr) begin
            case (paddr[2])
                lsu_pkg::REG_BASE_SPEED: r_cfg.base_speed <= pwdata;
                lsu_pkg::REG_STEP_RATIO: r_cfg.step_ratio <= pwdata[lsu_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lsu_pkg::REG_BASE_SPEED: prdata = r_cfg.base_speed;
            lsu_pkg::REG_STEP_RATIO: prdata = 32'(r_cfg.step_ratio);
            default:                 prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/lsu_front.sv
// Front stages: differences, upwind selection, squares, speed magnitudes, sums.
// Depends on lsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsu_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic signed [31:0]          i_centre_value,
    input  wire logic signed [31:0]          i_left_value,
    input  wire logic signed [31:0]          i_right_value,
    input  wire logic signed [31:0]          i_upper_value,
    input  wire logic signed [31:0]          i_lower_value,
    input  wire logic [lsu_pkg::FAC_W-1:0]   i_image_factor,
    input  wire logic signed [31:0]          i_curvature_speed,
    input  wire lsu_pkg::t_cfg               i_cfg,
    output logic                             o_valid,
    output lsu_pkg::t_side                   o_side,
    output logic [lsu_pkg::RAD_W-1:0]        o_rad_up,
    output logic [lsu_pkg::RAD_W-1:0]        o_rad_c
);
    localparam int PW = lsu_pkg::PART_W;
    localparam int SW = lsu_pkg::SQ_W;
    localparam int RW = lsu_pkg::RAD_W;
    localparam int QW = lsu_pkg::PROD_W;

    function automatic logic [PW-1:0] pos_part(input logic signed [PW:0] d);
        logic [PW:0] t;
        t = d;
        return (d > 0) ? t[PW-1:0] : '0;
    endfunction

    function automatic logic [PW-1:0] neg_part(input logic signed [PW:0] d);
        logic [PW:0] t;
        t = -d;
        return (d < 0) ? t[PW-1:0] : '0;
    endfunction

    // stage 1
    logic signed [PW:0] dl, dr, du, dd, gx, gy;
    logic [PW:0]        gx_m, gy_m;
    logic [31:0]        cs_abs, cv_abs;
    logic               cs_pos, curv_pos;
    logic               r_s1_v;
    logic signed [31:0] r_s1_c;
    logic [PW-1:0]      r_s1_a, r_s1_b, r_s1_e, r_s1_f, r_s1_gx, r_s1_gy;
    logic [QW-1:0]      r_s1_csp, r_s1_dsp;
    logic               r_s1_cs_pos, r_s1_curv_pos;

    always_comb begin
        dl = (PW+1)'(i_centre_value) - (PW+1)'(i_left_value);
        dr = (PW+1)'(i_right_value) - (PW+1)'(i_centre_value);
        du = (PW+1)'(i_centre_value) - (PW+1)'(i_upper_value);
        dd = (PW+1)'(i_lower_value) - (PW+1)'(i_centre_value);
        gx = (PW+1)'(i_right_value) - (PW+1)'(i_left_value);
        gy = (PW+1)'(i_lower_value) - (PW+1)'(i_upper_value);
        gx_m = gx[PW] ? (PW+1)'(-gx) : (PW+1)'(gx);
        gy_m = gy[PW] ? (PW+1)'(-gy) : (PW+1)'(gy);
        cs_abs = i_cfg.base_speed[31] ? 32'(-i_cfg.base_speed)
                                      : 32'(i_cfg.base_speed);
        cv_abs = i_curvature_speed[31] ? 32'(-i_curvature_speed) : 32'(i_curvature_speed);
        cs_pos   = i_cfg.base_speed > 32'sd0;
        curv_pos = i_curvature_speed > 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_c        <= i_centre_value;
            // choose the upwind side by the sign of the constant speed
            r_s1_a        <= cs_pos ? pos_part(dl) : neg_part(dl);
            r_s1_b        <= cs_pos ? neg_part(dr) : pos_part(dr);
            r_s1_e        <= cs_pos ? pos_part(du) : neg_part(du);
            r_s1_f        <= cs_pos ? neg_part(dd) : pos_part(dd);
            r_s1_gx       <= gx_m[PW-1:0];
            r_s1_gy       <= gy_m[PW-1:0];
            r_s1_csp      <= QW'(i_image_factor) * QW'(cs_abs);
            r_s1_dsp      <= QW'(i_image_factor) * QW'(cv_abs);
            r_s1_cs_pos   <= cs_pos;
            r_s1_curv_pos <= curv_pos;
        end
    end

    // stage 2
    logic [QW-1:0]      cs_rnd, ds_rnd;
    logic               r_s2_v;
    lsu_pkg::t_side     r_s2_side;
    logic [SW-1:0]      r_s2_aa, r_s2_bb, r_s2_ee, r_s2_ff, r_s2_xx, r_s2_yy;

    assign cs_rnd = r_s1_csp + QW'(lsu_pkg::ROUND_HALF);
    assign ds_rnd = r_s1_dsp + QW'(lsu_pkg::ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (i_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_aa <= SW'(r_s1_a) * SW'(r_s1_a);
            r_s2_bb <= SW'(r_s1_b) * SW'(r_s1_b);
            r_s2_ee <= SW'(r_s1_e) * SW'(r_s1_e);
            r_s2_ff <= SW'(r_s1_f) * SW'(r_s1_f);
            r_s2_xx <= SW'(r_s1_gx) * SW'(r_s1_gx);
            r_s2_yy <= SW'(r_s1_gy) * SW'(r_s1_gy);
            r_s2_side.centre   <= r_s1_c;
            r_s2_side.cs_mag   <= cs_rnd[QW-1:16];
            r_s2_side.ds_mag   <= ds_rnd[QW-1:16];
            r_s2_side.cs_pos   <= r_s1_cs_pos;
            r_s2_side.curv_pos <= r_s1_curv_pos;
        end
    end

    // stage 3
    logic               r_s3_v;
    lsu_pkg::t_side     r_s3_side;
    logic [RW-1:0]      r_s3_up, r_s3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (i_en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_up   <= (RW'(r_s2_aa) + RW'(r_s2_bb)) + (RW'(r_s2_ee) + RW'(r_s2_ff));
            r_s3_c    <= RW'(r_s2_xx) + RW'(r_s2_yy);
            r_s3_side <= r_s2_side;
        end
    end

    assign o_valid  = r_s3_v;
    assign o_side   = r_s3_side;
    assign o_rad_up = r_s3_up;
    assign o_rad_c  = r_s3_c;
endmodule
`default_nettype wire

// File: rtl/lsu_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on lsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsu_sqrt #(
    parameter int RAD_W = lsu_pkg::RAD_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [RAD_W-1:0]   i_rad,
    output logic [RAD_W/2-1:0]      o_root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in, cur, trial;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? cur - trial : cur;
                r_root[k] <= {root_in[ROOT_W-2:0], ge};
                r_rad[k]  <= {rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
endmodule
`default_nettype wire

// File: rtl/lsu_back.sv
// Back stages: term products, signed sum, step product, final subtract, clip.
// Depends on lsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsu_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire lsu_pkg::t_side               i_side,
    input  wire logic [lsu_pkg::ROOT_W-1:0]   i_root_up,
    input  wire logic [lsu_pkg::ROOT_W-1:0]   i_root_c,
    input  wire logic [lsu_pkg::STEP_W-1:0]   i_step_ratio,
    output logic                              o_valid,
    output logic signed [31:0]                o_new_value,
    output logic                              o_saturated
);
    localparam int TW  = lsu_pkg::TERM_W;
    localparam int PW  = lsu_pkg::TPART_W;
    localparam int SW  = lsu_pkg::TOT_W;
    localparam int MW  = lsu_pkg::TMAG_W;
    localparam int LW  = lsu_pkg::TLO_W;
    localparam int HW  = lsu_pkg::THI_W;
    localparam int DW  = lsu_pkg::DPROD_W;
    localparam int GW  = lsu_pkg::DMAG_W;
    localparam int RW  = lsu_pkg::RES_W;
    localparam int STW = lsu_pkg::STEP_W;

    logic [6:1] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    // B1: term products
    logic [TW-1:0]      r_b1_pu, r_b1_pc;
    logic               r_b1_csp, r_b1_cvp;
    logic signed [31:0] r_b1_c;
    // B2: rounded terms
    logic [TW-1:0]      ru, rc;
    logic [PW-1:0]      r_b2_tu, r_b2_tc;
    logic               r_b2_csp, r_b2_cvp;
    logic signed [31:0] r_b2_c;
    // B3: signed sum and magnitude
    logic signed [SW-1:0] su, sc, tot;
    logic [SW-1:0]        tmag;
    logic [MW-1:0]        r_b3_mag;
    logic                 r_b3_neg;
    logic signed [31:0]   r_b3_c;
    // B4: step partial products
    logic [DW-1:0]      r_b4_lo, r_b4_hi;
    logic               r_b4_neg;
    logic signed [31:0] r_b4_c;
    // B5: rounded step
    logic [DW-1:0]      dsum;
    logic [GW-1:0]      r_b5_dmag;
    logic               r_b5_neg;
    logic signed [31:0] r_b5_c;
    // B6: subtract and clip
    logic signed [RW-1:0] res;
    logic                 sat;
    logic signed [31:0]   r_b6_nv;
    logic                 r_b6_sat;

    assign ru   = r_b1_pu + TW'(lsu_pkg::ROUND_HALF);
    assign rc   = r_b1_pc + TW'(lsu_pkg::ROUND_HALF);
    assign su   = r_b2_csp ? SW'(r_b2_tu) : -SW'(r_b2_tu);
    assign sc   = r_b2_cvp ? SW'(r_b2_tc) : -SW'(r_b2_tc);
    assign tot  = su + sc;
    assign tmag = tot[SW-1] ? -tot : tot;
    assign dsum = r_b4_lo + (r_b4_hi << LW) + DW'(lsu_pkg::ROUND_HALF);
    assign res  = r_b5_neg ? RW'(r_b5_c) + RW'(r_b5_dmag) : RW'(r_b5_c) - RW'(r_b5_dmag);
    assign sat  = (res[RW-1:31] != '0) && (res[RW-1:31] != '1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_pu  <= TW'(i_side.cs_mag) * TW'(i_root_up);
            r_b1_pc  <= TW'(i_side.ds_mag) * TW'(i_root_c >> 1);
            r_b1_csp <= i_side.cs_pos;
            r_b1_cvp <= i_side.curv_pos;
            r_b1_c   <= i_side.centre;

            r_b2_tu  <= ru[TW-1:16];
            r_b2_tc  <= rc[TW-1:16];
            r_b2_csp <= r_b1_csp;
            r_b2_cvp <= r_b1_cvp;
            r_b2_c   <= r_b1_c;

            r_b3_mag <= tmag[MW-1:0];
            r_b3_neg <= tot[SW-1];
            r_b3_c   <= r_b2_c;

            // split the wide magnitude so each product stays narrow
            r_b4_lo  <= DW'(i_step_ratio) * DW'(r_b3_mag[LW-1:0]);
            r_b4_hi  <= DW'((STW+HW)'(i_step_ratio) * (STW+HW)'(r_b3_mag[MW-1:LW]));
            r_b4_neg <= r_b3_neg;
            r_b4_c   <= r_b3_c;

            r_b5_dmag <= dsum[DW-1:16];
            r_b5_neg  <= r_b4_neg;
            r_b5_c    <= r_b4_c;

            r_b6_sat <= sat;
            r_b6_nv  <= !sat ? res[31:0] : (res[RW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        end
    end

    assign o_valid     = r_v[6];
    assign o_new_value = r_b6_nv;
    assign o_saturated = r_b6_sat;
endmodule
`default_nettype wire

// File: rtl/lsu_checker.sv
// Port checker for the level set upwind update core, bound to the top level.
// Depends on level_set_upwind_update_core.
`timescale 1ns / 1ps
`default_nettype none
module lsu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_new_value,
    input wire logic        i_saturated
);
    // no result may appear right after a reset cycle
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_new_value))
        else $error("stalled result changed");

    // a clipped result is one of the two range limits
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |->
            (i_new_value == 32'h7FFF_FFFF || i_new_value == 32'h8000_0000))
        else $error("clip flag with value inside range");

    // the skid empties whenever the receiver takes
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_ready) |-> i_in_ready)
        else $error("request side stalled though receiver was ready");
endmodule

bind level_set_upwind_update_core lsu_checker u_lsu_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_pix.ready),
    .i_out_valid(o_upd.valid),
    .i_out_ready(o_upd.ready),
    .i_new_value(o_upd.new_value),
    .i_saturated(o_upd.saturated)
);
`default_nettype wire
